// ----- rtl/core/i2crt_pkg.sv -----
// Shared types and codes for the I2C register transaction sequencer.
// Used by i2crt_step and i2c_register_transaction_fsm_top; no dependencies.
package i2crt_pkg;

   // Controller events
   typedef enum logic [2:0] {
      CMD_START     = 3'd0,
      CMD_ACK       = 3'd1,
      CMD_NACK      = 3'd2,
      CMD_BYTE      = 3'd3,
      CMD_STOP_DONE = 3'd4
   } cmd_type;

   // Commands to the bus controller
   typedef enum logic [2:0] {
      BUS_NONE  = 3'd0,
      BUS_START = 3'd1,
      BUS_STOP  = 3'd2,
      BUS_ACK   = 3'd3,
      BUS_NACK  = 3'd4
   } bus_op_type;

   // Transaction phase, one-hot
   typedef enum logic [5:0] {
      PH_START     = 6'b000001,
      PH_READ_CMD  = 6'b000010,
      PH_WRITE_CMD = 6'b000100,
      PH_WAIT_READ = 6'b001000,
      PH_DATA      = 6'b010000,
      PH_STOP      = 6'b100000
   } phase_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_TARGET_ADDRESS  = 3'd0;
   localparam logic [2:0] CSR_REGISTER_INDEX  = 3'd1;
   localparam logic [2:0] CSR_READ_NOT_WRITE  = 3'd2;
   localparam logic [2:0] CSR_BYTE_COUNT      = 3'd3;
   localparam logic [2:0] CSR_WRITE_WORD      = 3'd4;
   localparam logic [2:0] CSR_MSB_FIRST_ORDER = 3'd5;

   typedef struct packed {
      logic [6:0]  target_address;
      logic [7:0]  register_index;
      logic        read_not_write;
      logic [1:0]  byte_count;
      logic [15:0] write_word;
      logic        msb_first_order;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic        first_byte_sent;
      logic [1:0]  bytes_left;
      logic [15:0] read_accum;
      logic        busy;
   } state_type;

   typedef struct packed {
      bus_op_type  bus_op;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [15:0] read_word;
      logic        busy_res;
      logic        done_res;
      logic        fault;
      logic        last;
   } result_type;

endpackage

// ----- rtl/core/i2crt_step.sv -----
// One event step of the I2C register transaction sequencer: next state and first result.
// Pure combinational; depends on i2crt_pkg.
module i2crt_step (
   input  i2crt_pkg::cfg_type    cfg,
   input  i2crt_pkg::state_type  cur,
   input  i2crt_pkg::cmd_type    cmd,
   input  logic [7:0]            rx_byte,
   output i2crt_pkg::state_type  nxt,
   output i2crt_pkg::result_type res,
   output logic                  stop_follows
);

   logic              ok;
   i2crt_pkg::bus_op_type op;
   logic              txv;
   logic [7:0]        txb;
   logic              done;
   logic [7:0]        addr_w;
   logic [7:0]        addr_r;

   assign addr_w = {cfg.target_address, 1'b0};
   assign addr_r = {cfg.target_address, 1'b1};

   always_comb begin
      nxt          = cur;
      ok           = 1'b0;
      op           = i2crt_pkg::BUS_NONE;
      txv          = 1'b0;
      txb          = 8'h00;
      done         = 1'b0;
      stop_follows = 1'b0;
      case (cmd)
         i2crt_pkg::CMD_START: begin
            if (!cur.busy) begin
               ok                  = 1'b1;
               nxt.busy            = 1'b1;
               nxt.phase           = i2crt_pkg::PH_START;
               nxt.first_byte_sent = 1'b0;
               nxt.read_accum      = 16'h0000;
               nxt.bytes_left      = cfg.byte_count[1] ? 2'd2 : 2'd1;
               op                  = i2crt_pkg::BUS_START;
               txv                 = 1'b1;
               txb                 = addr_w;
            end
         end
         i2crt_pkg::CMD_ACK: begin
            if (cur.busy) begin
               case (cur.phase)
                  i2crt_pkg::PH_START: begin
                     ok        = 1'b1;
                     nxt.phase = cfg.read_not_write ? i2crt_pkg::PH_READ_CMD
                                                    : i2crt_pkg::PH_WRITE_CMD;
                     txv       = 1'b1;
                     txb       = cfg.register_index;
                  end
                  i2crt_pkg::PH_READ_CMD: begin
                     ok        = 1'b1;
                     nxt.phase = i2crt_pkg::PH_WAIT_READ;
                     op        = i2crt_pkg::BUS_START;
                     txv       = 1'b1;
                     txb       = addr_r;
                  end
                  i2crt_pkg::PH_WRITE_CMD: begin
                     ok  = 1'b1;
                     txv = 1'b1;
                     if (cur.bytes_left == 2'd2 && !cur.first_byte_sent) begin
                        nxt.first_byte_sent = 1'b1;
                        txb                 = cfg.write_word[7:0];
                     end else if (cur.bytes_left == 2'd2) begin
                        nxt.phase = i2crt_pkg::PH_DATA;
                        txb       = cfg.write_word[15:8];
                     end else begin
                        nxt.phase = i2crt_pkg::PH_DATA;
                        txb       = cfg.write_word[7:0];
                     end
                  end
                  i2crt_pkg::PH_WAIT_READ: begin
                     ok        = 1'b1;
                     nxt.phase = i2crt_pkg::PH_DATA;
                  end
                  i2crt_pkg::PH_DATA: begin
                     if (!cfg.read_not_write) begin
                        ok        = 1'b1;
                        nxt.phase = i2crt_pkg::PH_STOP;
                        op        = i2crt_pkg::BUS_STOP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         i2crt_pkg::CMD_NACK: begin
            // Re-send address+R on every NACK while waiting for the read
            if (cur.busy && cur.phase == i2crt_pkg::PH_WAIT_READ) begin
               ok  = 1'b1;
               op  = i2crt_pkg::BUS_START;
               txv = 1'b1;
               txb = addr_r;
            end
         end
         i2crt_pkg::CMD_BYTE: begin
            if (cur.busy && cur.phase == i2crt_pkg::PH_DATA && cfg.read_not_write
                && cur.bytes_left != 2'd0) begin
               ok = 1'b1;
               if (cur.bytes_left == 2'd2) begin
                  nxt.bytes_left = 2'd1;
                  nxt.read_accum = cfg.msb_first_order ? {rx_byte, 8'h00}
                                                       : {8'h00, rx_byte};
                  op             = i2crt_pkg::BUS_ACK;
               end else begin
                  nxt.bytes_left = 2'd0;
                  // Second byte lands opposite the first; a single byte lands low
                  if (cfg.byte_count[1] && !cfg.msb_first_order) begin
                     nxt.read_accum = cur.read_accum | {rx_byte, 8'h00};
                  end else begin
                     nxt.read_accum = cur.read_accum | {8'h00, rx_byte};
                  end
                  nxt.phase    = i2crt_pkg::PH_STOP;
                  op           = i2crt_pkg::BUS_NACK;
                  stop_follows = 1'b1;
               end
            end
         end
         i2crt_pkg::CMD_STOP_DONE: begin
            if (cur.busy && cur.phase == i2crt_pkg::PH_STOP) begin
               ok        = 1'b1;
               nxt.phase = i2crt_pkg::PH_START;
               nxt.busy  = 1'b0;
               done      = 1'b1;
            end
         end
         default: ;
      endcase

      // A faulting event leaves the state untouched
      if (!ok) begin
         nxt = cur;
      end

      res.bus_op    = op;
      res.tx_valid  = txv;
      res.tx_byte   = txb;
      res.read_word = nxt.read_accum;
      res.busy_res  = nxt.busy;
      res.done_res  = done;
      res.fault     = !ok;
      res.last      = !stop_follows;
   end

endmodule

// ----- rtl/core/i2c_register_transaction_fsm_top.sv -----
// Top level of the I2C master register transaction sequencer.
// Holds configuration, transaction state and the result register; uses i2crt_pkg, i2crt_step.
//
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   req_tdata: cmd, rx_byte
// rsp      out        rsp_tvalid/rsp_tready   rsp_tdata: controller command and status;
//                                             rsp_tlast: final item of the event
// csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// Each event is evaluated in the cycle it is accepted and its first result item lands in
// the result register at that edge; one event per cycle is taken while rsp keeps up.
// A byte-received event that ends a read gives two items (NACK, then STOP): the STOP item
// follows from the same register once the NACK item is taken, and req stalls until then.
// req_tready stays high while the result register is empty or is being emptied with no
// STOP item still owed. Synchronous active-high reset clears state and the valid flags and
// sets configuration to its defaults; the csr port is always ready.
module i2c_register_transaction_fsm_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] cmd, [10:3] rx_byte, [15:11] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] bus_op, [3] tx_valid, [11:4] tx_byte,
                                    // [27:12] read_word, [28] busy_res, [29] done_res,
                                    // [30] fault, [31] zero
   output logic        rsp_tlast,   // last item of this event
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   i2crt_pkg::cfg_type    cfg_ff;
   i2crt_pkg::cfg_type    cfg_in;
   i2crt_pkg::state_type  state_ff;
   i2crt_pkg::state_type  state_in;
   i2crt_pkg::state_type  step_state;
   i2crt_pkg::result_type step_res;
   logic                  step_stop;
   i2crt_pkg::result_type out_ff;
   i2crt_pkg::result_type out_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  stop_owed_ff;
   logic                  stop_owed_in;
   logic                  req_take;
   logic                  rsp_take;

   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            i2crt_pkg::CSR_TARGET_ADDRESS:  cfg_in.target_address  = csr_data[6:0];
            i2crt_pkg::CSR_REGISTER_INDEX:  cfg_in.register_index  = csr_data[7:0];
            i2crt_pkg::CSR_READ_NOT_WRITE:  cfg_in.read_not_write  = csr_data[0];
            i2crt_pkg::CSR_BYTE_COUNT:      cfg_in.byte_count      = csr_data[1:0];
            i2crt_pkg::CSR_WRITE_WORD:      cfg_in.write_word      = csr_data;
            i2crt_pkg::CSR_MSB_FIRST_ORDER: cfg_in.msb_first_order = csr_data[0];
            default: ;
         endcase
      end
   end

   // Event evaluation
   i2crt_step u_step (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .cmd          (i2crt_pkg::cmd_type'(req_tdata[2:0])),
      .rx_byte      (req_tdata[10:3]),
      .nxt          (step_state),
      .res          (step_res),
      .stop_follows (step_stop)
   );

   assign rsp_take   = rsp_valid_ff && rsp_tready;
   assign req_tready = !rsp_valid_ff || (rsp_tready && !stop_owed_ff);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      state_in     = req_take ? step_state : state_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      stop_owed_in = stop_owed_ff;
      if (req_take) begin
         // Load the new event's first item
         out_in       = step_res;
         rsp_valid_in = 1'b1;
         stop_owed_in = step_stop;
      end else if (rsp_take) begin
         if (stop_owed_ff) begin
            // Turn the NACK item into the trailing STOP item
            out_in.bus_op = i2crt_pkg::BUS_STOP;
            out_in.last   = 1'b1;
            stop_owed_in  = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_address  <= 7'd0;
         cfg_ff.register_index  <= 8'd0;
         cfg_ff.read_not_write  <= 1'b0;
         cfg_ff.byte_count      <= 2'd1;
         cfg_ff.write_word      <= 16'd0;
         cfg_ff.msb_first_order <= 1'b1;
         state_ff.phase           <= i2crt_pkg::PH_START;
         state_ff.first_byte_sent <= 1'b0;
         state_ff.bytes_left      <= 2'd0;
         state_ff.read_accum      <= 16'd0;
         state_ff.busy            <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stop_owed_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stop_owed_ff <= stop_owed_in;
      end
   end

   // Result payload, no reset
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {1'b0, out_ff.fault, out_ff.done_res, out_ff.busy_res,
                        out_ff.read_word, out_ff.tx_byte, out_ff.tx_valid, out_ff.bus_op};

endmodule
